>>> rtl/rfd_pkg.sv
// Shared types and constants for the FastCGI response deframer.
package rfd_pkg;

    localparam logic [2:0] KIND_CONSUMED = 3'd0;
    localparam logic [2:0] KIND_NAMEVAL  = 3'd1;
    localparam logic [2:0] KIND_BODY     = 3'd2;
    localparam logic [2:0] KIND_STDERR   = 3'd3;
    localparam logic [2:0] KIND_COMPLETE = 3'd4;
    localparam logic [2:0] KIND_FAULT    = 3'd5;
    localparam logic [2:0] KIND_IGNORED  = 3'd6;

    localparam logic [7:0] REC_END_REQUEST = 8'd3;
    localparam logic [7:0] REC_STDOUT      = 8'd6;
    localparam logic [7:0] REC_STDERR      = 8'd7;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [2:0] HDR_TYPE    = 3'd1;
    localparam logic [2:0] HDR_ID_HI   = 3'd2;
    localparam logic [2:0] HDR_ID_LO   = 3'd3;
    localparam logic [2:0] HDR_LEN_HI  = 3'd4;
    localparam logic [2:0] HDR_LEN_LO  = 3'd5;
    localparam logic [2:0] HDR_PAD     = 3'd6;
    localparam logic [2:0] HDR_LAST    = 3'd7;

    localparam logic [2:0] END_PROTO_IDX = 3'd4;
    localparam logic [2:0] END_IDX_MAX   = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CONTENT,
        PH_PADDING,
        PH_STOPPED
    } phase_t;

    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
        logic       is_cr;
        logic       is_lf;
    } in_entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic        header_end;
        logic [15:0] req_id;
        logic [31:0] app_code;
        logic [7:0]  proto_code;
    } result_t;

endpackage

>>> rtl/rfd_fifo.sv
// Small register FIFO used for the input and result queues.
module rfd_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/rfd_front.sv
// Front end: takes input beats, tags separator characters and queues them.
module rfd_front
    import rfd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    input  logic       pop,
    output logic       empty,
    output in_entry_t  entry
);
    in_entry_t in_beat;
    logic [$bits(in_entry_t)-1:0] head;

    always_comb
    begin
        in_beat.restart   = req_type;
        in_beat.data_byte = data_byte;
        in_beat.is_cr     = (data_byte == CHAR_CR);
        in_beat.is_lf     = (data_byte == CHAR_LF);
    end

    rfd_fifo #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(in_entry_t))
    ) u_in_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_beat),
        .full  (full),
        .pop   (pop),
        .rdata (head),
        .empty (empty)
    );

    assign entry = in_entry_t'(head);

endmodule

>>> rtl/rfd_engine.sv
// Back end: record parser that turns one queued beat into one result per cycle while the result queue has room.
module rfd_engine
    import rfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_entry_t in_entry,
    output logic      in_take,
    input  logic      res_ready,
    output logic      res_push,
    output result_t   res
);
    phase_t      phase_reg, phase_next;
    logic [2:0]  hcount_reg, hcount_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [15:0] rid_reg, rid_next;
    logic [15:0] clen_reg, clen_next;
    logic [7:0]  plen_reg, plen_next;
    logic        body_reg, body_next;
    logic [1:0]  sep_reg, sep_next;
    logic [2:0]  eidx_reg, eidx_next;
    logic [31:0] app_reg, app_next;
    logic [7:0]  proto_reg, proto_next;

    logic        fire;
    logic [7:0]  b;
    logic [15:0] clen_dec;
    logic        last;
    logic [7:0]  plen_dec;
    logic        sep_hit;
    logic [2:0]  sep_m;
    logic [31:0] app_acc;
    logic [31:0] app_fill;
    logic        stop;
    logic [2:0]  kind;
    logic [7:0]  ob;
    logic        hend;

    assign fire     = in_valid & res_ready;
    assign in_take  = fire;
    assign res_push = fire;
    assign b        = in_entry.data_byte;
    assign clen_dec = clen_reg - 1'b1;
    assign last     = (clen_dec == '0);
    assign plen_dec = plen_reg - 1'b1;
    assign sep_hit  = sep_reg[0] ? in_entry.is_lf : in_entry.is_cr;
    assign sep_m    = sep_hit ? ({1'b0, sep_reg} + 3'd1) : {2'b00, in_entry.is_cr};
    assign app_acc  = {app_reg[23:0], b};

    always_comb
    begin
        case (eidx_reg[1:0])
            2'd0:    app_fill = {app_acc[7:0], 24'd0};
            2'd1:    app_fill = {app_acc[15:0], 16'd0};
            2'd2:    app_fill = {app_acc[23:0], 8'd0};
            default: app_fill = app_acc;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        rtype_next  = rtype_reg;
        rid_next    = rid_reg;
        clen_next   = clen_reg;
        plen_next   = plen_reg;
        body_next   = body_reg;
        sep_next    = sep_reg;
        eidx_next   = eidx_reg;
        app_next    = app_reg;
        proto_next  = proto_reg;
        stop        = 1'b0;
        kind        = KIND_CONSUMED;
        ob          = '0;
        hend        = 1'b0;

        if (fire)
        begin
            if (in_entry.restart)
            begin
                phase_next  = PH_HEADER;
                hcount_next = '0;
                rtype_next  = '0;
                rid_next    = '0;
                clen_next   = '0;
                plen_next   = '0;
                body_next   = 1'b0;
                sep_next    = '0;
                eidx_next   = '0;
                app_next    = '0;
                proto_next  = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_STOPPED:
                    begin
                        kind = KIND_IGNORED;
                    end
                    PH_HEADER:
                    begin
                        hcount_next = hcount_reg + 1'b1;
                        case (hcount_reg)
                            HDR_TYPE:   rtype_next = b;
                            HDR_ID_HI:  rid_next   = {b, rid_reg[7:0]};
                            HDR_ID_LO:  rid_next   = {rid_reg[15:8], b};
                            HDR_LEN_HI: clen_next  = {b, clen_reg[7:0]};
                            HDR_LEN_LO: clen_next  = {clen_reg[15:8], b};
                            HDR_PAD:    plen_next  = b;
                            default:    ;
                        endcase
                        if (hcount_reg == HDR_LAST)
                        begin
                            eidx_next = '0;
                            if (rtype_reg == REC_END_REQUEST)
                            begin
                                app_next   = '0;
                                proto_next = '0;
                            end
                            if (clen_reg != '0)
                            begin
                                phase_next = PH_CONTENT;
                            end
                            else if (rtype_reg == REC_END_REQUEST)
                            begin
                                phase_next = PH_STOPPED;
                                kind       = KIND_COMPLETE;
                            end
                            else
                            begin
                                phase_next = (plen_reg != '0) ? PH_PADDING : PH_HEADER;
                            end
                        end
                    end
                    PH_CONTENT:
                    begin
                        clen_next = clen_dec;
                        if (rtype_reg == REC_STDOUT)
                        begin
                            if (body_reg)
                            begin
                                kind = KIND_BODY;
                                ob   = b;
                            end
                            else if (sep_m[2])
                            begin
                                kind      = KIND_NAMEVAL;
                                ob        = b;
                                hend      = 1'b1;
                                body_next = 1'b1;
                                sep_next  = '0;
                            end
                            else if (last)
                            begin
                                kind     = KIND_FAULT;
                                stop     = 1'b1;
                                sep_next = sep_m[1:0];
                            end
                            else
                            begin
                                kind     = KIND_NAMEVAL;
                                ob       = b;
                                sep_next = sep_m[1:0];
                            end
                        end
                        else if (rtype_reg == REC_STDERR)
                        begin
                            kind = KIND_STDERR;
                            ob   = b;
                        end
                        else if (rtype_reg == REC_END_REQUEST)
                        begin
                            if (eidx_reg < END_PROTO_IDX)
                            begin
                                app_next = app_acc;
                            end
                            else if (eidx_reg == END_PROTO_IDX)
                            begin
                                proto_next = b;
                            end
                            if (eidx_reg != END_IDX_MAX)
                            begin
                                eidx_next = eidx_reg + 1'b1;
                            end
                            if (eidx_reg == END_PROTO_IDX)
                            begin
                                kind = KIND_COMPLETE;
                                stop = 1'b1;
                            end
                            else if (last && (eidx_reg < END_PROTO_IDX))
                            begin
                                app_next = app_fill;
                                kind     = KIND_COMPLETE;
                                stop     = 1'b1;
                            end
                        end
                        if (stop)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else if (last)
                        begin
                            phase_next = (plen_reg != '0) ? PH_PADDING : PH_HEADER;
                        end
                    end
                    PH_PADDING:
                    begin
                        plen_next = plen_dec;
                        if (plen_dec == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                endcase
            end
        end

        res.kind       = kind;
        res.out_byte   = ob;
        res.header_end = hend;
        res.req_id     = rid_next;
        res.app_code   = (kind == KIND_COMPLETE) ? app_next : '0;
        res.proto_code = (kind == KIND_COMPLETE) ? proto_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            rtype_reg  <= '0;
            rid_reg    <= '0;
            clen_reg   <= '0;
            plen_reg   <= '0;
            body_reg   <= 1'b0;
            sep_reg    <= '0;
            eidx_reg   <= '0;
            app_reg    <= '0;
            proto_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            rtype_reg  <= rtype_next;
            rid_reg    <= rid_next;
            clen_reg   <= clen_next;
            plen_reg   <= plen_next;
            body_reg   <= body_next;
            sep_reg    <= sep_next;
            eidx_reg   <= eidx_next;
            app_reg    <= app_next;
            proto_reg  <= proto_next;
        end
    end

endmodule

>>> rtl/fastcgi_response_deframer_top.sv
// Top level of the FastCGI response deframer.
// Splits a FastCGI response byte stream into records and yields exactly one result beat per
// input beat: name-value bytes up to and including CRLFCRLF (last byte flagged by header_end),
// then stdout body bytes, stderr bytes, a completion beat carrying app_code and
// proto_code, a fault beat when stdout content ends without the separator, and ignored
// beats after completion or fault until a restart beat (req_type = 1). Both sides are queues:
// push while full is low, pop while empty is low. The block takes one byte per cycle
// sustained while the result queue has room; each byte is held in the input queue, and
// the record parser takes it from there and writes its result straight into the result
// queue, and it sets the rate. IN_DEPTH and OUT_DEPTH size the two queues (at least 2).
module fastcgi_response_deframer_top
    import rfd_pkg::*;
#(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic        header_end,
    output logic [15:0] req_id,
    output logic [31:0] app_code,
    output logic [7:0]  proto_code
);
    in_entry_t entry;
    logic      entry_empty;
    logic      entry_take;
    logic      res_full;
    logic      res_push;
    result_t   res;
    logic [$bits(result_t)-1:0] res_head;
    result_t   head;

    rfd_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .data_byte (data_byte),
        .pop       (entry_take),
        .empty     (entry_empty),
        .entry     (entry)
    );

    rfd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (~entry_empty),
        .in_entry  (entry),
        .in_take   (entry_take),
        .res_ready (~res_full),
        .res_push  (res_push),
        .res       (res)
    );

    rfd_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign head       = result_t'(res_head);
    assign kind       = head.kind;
    assign out_byte   = head.out_byte;
    assign header_end = head.header_end;
    assign req_id     = head.req_id;
    assign app_code   = head.app_code;
    assign proto_code = head.proto_code;

endmodule

>>> rtl/rfd_checker.sv
// Port-level checks for the deframer, bound to the top level.
module rfd_checker
    import rfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  kind,
    input logic        header_end,
    input logic [31:0] app_code,
    input logic [7:0]  proto_code
);

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (kind != 3'd7))
        else $error("result kind out of range");

    a_hend_nameval: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && header_end) |-> (kind == KIND_NAMEVAL))
        else $error("header_end on a beat that is not a name-value byte");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind != KIND_COMPLETE)) |-> (app_code == '0 && proto_code == '0))
        else $error("status fields set outside a completion beat");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result dropped");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> (empty || $past(push && !full)))
        else $error("result shown without an accepted beat after reset");

endmodule

bind fastcgi_response_deframer_top rfd_checker u_rfd_checker (.*);
